@@ sv/rarmt_pkg.sv @@
// Shared types and constants of the range-add range-max tree.
package rarmt_pkg;

  // Saturation bound of every node update and every carry sum.
  localparam logic signed [63:0] SAT_LIMIT = 64'sh4000_0000_0000_0000;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_PEAK    = 2'd2,
    OP_EXCEEDS = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [10:0]        start_req;
    logic [10:0]        end_req;
    logic [62:0]        amount;
    logic signed [63:0] limit;
  } in_t;

  typedef struct packed {
    logic signed [63:0] peak_value;
    logic               over_limit;
  } out_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ENTER,
    S_NODE,
    S_PL_RD,
    S_PL_WR,
    S_PR_WR,
    S_PUSHL,
    S_POP,
    S_RESUME,
    S_UP_RL,
    S_UP_RR,
    S_UP_WR,
    S_FINISH
  } state_e;

  // Which child of a saved node has been walked.
  typedef enum logic {
    PH_LEFT_DONE,
    PH_RIGHT_DONE
  } phase_e;

endpackage

@@ sv/rarmt_alu.sv @@
// Pair of saturating adders shared by every node update and carry sum.
module rarmt_alu (
  input  logic signed [63:0] a0_i,
  input  logic signed [63:0] b0_i,
  input  logic signed [63:0] a1_i,
  input  logic signed [63:0] b1_i,
  output logic signed [63:0] s0_o,
  output logic signed [63:0] s1_o
);
  import rarmt_pkg::*;

  localparam logic signed [65:0] HI = {2'b00, SAT_LIMIT};
  localparam logic signed [65:0] LO = -HI;

  logic signed [65:0] sum0, sum1;

  // Sums are formed two bits wider, then clamped to the saturation bound.
  always_comb begin
    sum0 = {{2{a0_i[63]}}, a0_i} + {{2{b0_i[63]}}, b0_i};
    sum1 = {{2{a1_i[63]}}, a1_i} + {{2{b1_i[63]}}, b1_i};
    if (sum0 > HI) begin
      s0_o = SAT_LIMIT;
    end else if (sum0 < LO) begin
      s0_o = -SAT_LIMIT;
    end else begin
      s0_o = sum0[63:0];
    end
    if (sum1 > HI) begin
      s1_o = SAT_LIMIT;
    end else if (sum1 < LO) begin
      s1_o = -SAT_LIMIT;
    end else begin
      s1_o = sum1[63:0];
    end
  end

endmodule

@@ sv/range_add_range_max_tree_core.sv @@
// Top level: lazy segment tree with range add and range max over a time axis.
//
// Input channel in_valid_i / in_stall_o carries one transaction of type in_t:
// add, remove, peak query or exceeds query over [start_req, end_req).
// Output channel out_valid_o / out_stall_i returns exactly one out_t for every
// input transaction, in order. A result sits in an output register, so the next
// input is taken while an earlier result still waits for the receiver.
// One transaction is worked at a time by a sequencer that walks the tree
// depth first with an explicit stack. The node memory has one read and one
// write port. A node outside the interval costs the least, a fully covered node
// more, and a partly covered node on an update the most, since its pending add,
// if any, is pushed to both children and its maximum is recomputed from them.
// At most about four nodes per level are visited, and a transaction with an
// empty interval skips the walk. The receiver stalling only delays the moment
// the next finished result may be loaded; nothing is lost.
// After reset, and after a remove brings the live count to zero, a clearing
// pass writes every node word, and during this pass
// in_stall_o is high.
module range_add_range_max_tree_core #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  rarmt_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rarmt_pkg::out_t out_data_o
);
  import rarmt_pkg::*;

  localparam int unsigned LVL   = $clog2(LEAVES);
  localparam int unsigned NW    = LVL + 1;
  localparam int unsigned NODES = 1 << NW;
  localparam int unsigned SW    = $clog2(LEAVES + 1);
  localparam int unsigned CW    = (SW > 11) ? SW : 11;
  localparam int unsigned STK   = LVL;
  localparam int unsigned SPW   = $clog2(STK + 1);
  localparam int unsigned SIW   = (STK > 1) ? $clog2(STK) : 1;
  localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);
  localparam logic [SW-1:0] ROOT_HI   = SW'(LEAVES);

  typedef struct packed {
    logic [NW-1:0]      idx;
    logic [SW-1:0]      lo;
    logic [SW-1:0]      hi;
    logic signed [63:0] carry;
    phase_e             ph;
  } frame_t;

  state_e state_q, state_d;
  frame_t cur_q, cur_d;
  frame_t stack_q [STK];
  frame_t stk_wdata;
  logic   stk_we;
  logic [SPW-1:0] sp_q, sp_d;

  logic [1:0]         op_q, op_d;
  logic [10:0]        ql_q, ql_d, qr_q, qr_d;
  logic signed [63:0] delta_q, delta_d, limit_q, limit_d;
  logic               walk_q, walk_d;
  logic               acc_any_q, acc_any_d;
  logic signed [63:0] acc_max_q, acc_max_d;
  logic signed [63:0] lpk_q, lpk_d;
  logic [31:0]        live_q, live_d;
  logic               present_q, present_d;
  logic [NW-1:0]      clr_q, clr_d;
  out_t               out_q, out_d;
  logic               out_valid_q, out_valid_d;

  // Node memory: peak in the upper half of a word, pending add in the lower.
  logic [127:0] mem [NODES];
  logic [127:0] rd_q, mem_wd;
  logic [NW-1:0] mem_wa, mem_ra;
  logic          mem_we;

  logic signed [63:0] a0, b0, a1, b1, s0, s1;
  logic signed [63:0] rd_peak, rd_pend, up_max;
  logic [CW-1:0] lo_x, hi_x, ql_x, qr_x;
  logic [SW-1:0] mid;
  logic [NW-1:0] lidx, ridx;
  logic [SPW-1:0] sp_dec;
  logic disjoint, full, is_upd, accept, start_walk, out_free, clr_need, val_gt;

  rarmt_alu u_alu (
    .a0_i (a0),
    .b0_i (b0),
    .a1_i (a1),
    .b1_i (b1),
    .s0_o (s0),
    .s1_o (s1)
  );

  // Geometry of the current node against the query interval.
  always_comb begin
    lo_x     = CW'(cur_q.lo);
    hi_x     = CW'(cur_q.hi);
    ql_x     = CW'(ql_q);
    qr_x     = CW'(qr_q);
    disjoint = (qr_x <= lo_x) || (hi_x <= ql_x);
    full     = (ql_x <= lo_x) && (hi_x <= qr_x);
    mid      = cur_q.lo + ((cur_q.hi - cur_q.lo) >> 1);
    lidx     = {cur_q.idx[NW-2:0], 1'b0};
    ridx     = {cur_q.idx[NW-2:0], 1'b1};
    rd_peak  = rd_q[127:64];
    rd_pend  = rd_q[63:0];
    up_max   = (lpk_q > rd_peak) ? lpk_q : rd_peak;
    is_upd   = (op_q == OP_ADD) || (op_q == OP_REMOVE);
    sp_dec   = sp_q - 1'b1;
    val_gt   = s0 > acc_max_q;
    out_free = !out_valid_q || !out_stall_i;
    clr_need = (op_q == OP_REMOVE) && walk_q && (live_q <= 32'd1);
    accept   = in_valid_i && (state_q == S_IDLE);
  end

  // Decide whether the item needs a tree walk at all.
  always_comb begin
    unique case (in_data_i.operation)
      OP_ADD:    start_walk = (in_data_i.end_req > in_data_i.start_req) &&
                              (in_data_i.amount != '0);
      OP_REMOVE: start_walk = (in_data_i.end_req > in_data_i.start_req) &&
                              (in_data_i.amount != '0) && present_q;
      default:   start_walk = (in_data_i.end_req > in_data_i.start_req) && present_q;
    endcase
  end

  // Operand selection for the shared adders.
  always_comb begin
    a0 = rd_peak;
    b0 = delta_q;
    a1 = rd_pend;
    b1 = delta_q;
    unique case (state_q)
      S_NODE: begin
        if (!is_upd) begin
          a0 = cur_q.carry;
          b0 = full ? rd_peak : rd_pend;
        end
      end
      S_PL_WR, S_PR_WR: begin
        b0 = cur_q.carry;
        b1 = cur_q.carry;
      end
      default: begin
      end
    endcase
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:  if (clr_q == LAST_NODE) state_d = S_IDLE;
      S_IDLE:   if (accept) state_d = start_walk ? S_ENTER : S_FINISH;
      S_ENTER:  state_d = disjoint ? S_POP : S_NODE;
      S_NODE: begin
        if (full) begin
          state_d = S_POP;
        end else if (is_upd && (rd_pend != '0)) begin
          state_d = S_PL_RD;
        end else begin
          state_d = S_PUSHL;
        end
      end
      S_PL_RD:  state_d = S_PL_WR;
      S_PL_WR:  state_d = S_PR_WR;
      S_PR_WR:  state_d = S_PUSHL;
      S_PUSHL:  state_d = S_ENTER;
      S_POP:    state_d = (sp_q == '0) ? S_FINISH : S_RESUME;
      S_RESUME: begin
        if (cur_q.ph == PH_LEFT_DONE) begin
          state_d = S_ENTER;
        end else begin
          state_d = is_upd ? S_UP_RL : S_POP;
        end
      end
      S_UP_RL:  state_d = S_UP_RR;
      S_UP_RR:  state_d = S_UP_WR;
      S_UP_WR:  state_d = S_POP;
      S_FINISH: if (out_free) state_d = clr_need ? S_CLEAR : S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath, memory and stack control.
  always_comb begin
    cur_d       = cur_q;
    sp_d        = sp_q;
    op_d        = op_q;
    ql_d        = ql_q;
    qr_d        = qr_q;
    delta_d     = delta_q;
    limit_d     = limit_q;
    walk_d      = walk_q;
    acc_any_d   = acc_any_q;
    acc_max_d   = acc_max_q;
    lpk_d       = lpk_q;
    live_d      = live_q;
    present_d   = present_q;
    clr_d       = clr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_wa      = cur_q.idx;
    mem_wd      = {s0, s1};
    mem_ra      = cur_q.idx;
    stk_we      = 1'b0;
    stk_wdata   = cur_q;

    // The output register empties when the receiver takes the transaction.
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
        clr_d  = clr_q + 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          op_d      = in_data_i.operation;
          ql_d      = in_data_i.start_req;
          qr_d      = in_data_i.end_req;
          limit_d   = in_data_i.limit;
          delta_d   = (in_data_i.operation == OP_REMOVE) ?
                      -$signed({1'b0, in_data_i.amount}) : $signed({1'b0, in_data_i.amount});
          walk_d    = start_walk;
          acc_any_d = 1'b0;
          acc_max_d = '0;
          sp_d      = '0;
          cur_d     = '{idx: NW'(1), lo: '0, hi: ROOT_HI, carry: '0, ph: PH_LEFT_DONE};
        end
      end
      S_NODE: begin
        if (is_upd) begin
          if (full) begin
            mem_we = 1'b1;
          end else begin
            cur_d.carry = rd_pend;
          end
        end else if (full) begin
          acc_any_d = 1'b1;
          acc_max_d = (!acc_any_q || val_gt) ? s0 : acc_max_q;
        end else begin
          cur_d.carry = s0;
        end
      end
      S_PL_RD: mem_ra = lidx;
      S_PL_WR: begin
        mem_we = 1'b1;
        mem_wa = lidx;
        mem_ra = ridx;
      end
      S_PR_WR: begin
        mem_we = 1'b1;
        mem_wa = ridx;
      end
      S_PUSHL: begin
        stk_we       = 1'b1;
        stk_wdata.ph = PH_LEFT_DONE;
        sp_d         = sp_q + 1'b1;
        cur_d.idx    = lidx;
        cur_d.hi     = mid;
      end
      S_POP: begin
        if (sp_q != '0) begin
          cur_d = stack_q[sp_dec[SIW-1:0]];
          sp_d  = sp_dec;
        end
      end
      S_RESUME: begin
        if (cur_q.ph == PH_LEFT_DONE) begin
          stk_we       = 1'b1;
          stk_wdata.ph = PH_RIGHT_DONE;
          sp_d         = sp_q + 1'b1;
          cur_d.idx    = ridx;
          cur_d.lo     = mid;
        end
      end
      S_UP_RL: mem_ra = lidx;
      S_UP_RR: begin
        mem_ra = ridx;
        lpk_d  = rd_peak;
      end
      S_UP_WR: begin
        mem_we = 1'b1;
        mem_wd = {up_max, 64'sd0};
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.peak_value = ((op_q == OP_PEAK) && acc_any_q) ? acc_max_q : '0;
          out_d.over_limit = (op_q == OP_EXCEEDS) && acc_any_q && (acc_max_q > limit_q);
          if (walk_q && (op_q == OP_ADD)) begin
            present_d = 1'b1;
            if (live_q != '1) live_d = live_q + 1'b1;
          end else if (walk_q && (op_q == OP_REMOVE)) begin
            live_d = (live_q != '0) ? live_q - 1'b1 : '0;
          end
          if (clr_need) begin
            present_d = 1'b0;
            clr_d     = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      sp_q        <= '0;
      live_q      <= '0;
      present_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      sp_q        <= sp_d;
      live_q      <= live_d;
      present_q   <= present_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    op_q      <= op_d;
    ql_q      <= ql_d;
    qr_q      <= qr_d;
    delta_q   <= delta_d;
    limit_q   <= limit_d;
    walk_q    <= walk_d;
    acc_any_q <= acc_any_d;
    acc_max_q <= acc_max_d;
    lpk_q     <= lpk_d;
    out_q     <= out_d;
    if (stk_we) stack_q[sp_q[SIW-1:0]] <= stk_wdata;
  end

  // Node memory with registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[mem_ra];
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The walk stack never grows beyond the tree depth.
  a_stack_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STK))
    else $error("walk stack overflow");

  // Live intervals imply a built tree.
  a_live_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (live_q != '0) |-> present_q)
    else $error("live count without tree");

  // A finished walk loads the output register.
  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && out_free) |=> out_valid_q)
    else $error("finished transaction not presented");

  // The node memory is never written while waiting for input.
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we)
    else $error("node write while idle");

endmodule
